// File: hdl/pkscavg_pkg.sv
package pkscavg_pkg;

  localparam int unsigned DataW = 32;

  // count mode codes
  localparam logic [1:0] CNT_NONE   = 2'd0;
  localparam logic [1:0] CNT_RECORD = 2'd1;
  localparam logic [1:0] CNT_FIELD  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_COUNT_MODE = 2'd0;
  localparam logic [1:0] REG_AVG_EN     = 2'd1;
  localparam logic [1:0] REG_WHOLE      = 2'd2;

  typedef struct packed {
    logic [1:0] count_mode;
    logic       avg_en;
    logic       whole_batch;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic add_rec;
    logic div_start;
    logic load_out;
    logic emit_final;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic close_need;
    logic need_div;
    logic div_done;
    logic out_free;
    logic last;
  } dp_stat_t;

endpackage

// File: hdl/pkscavg_div.sv
module pkscavg_div import pkscavg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  output logic             done_o,
  output logic [DataW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DataW + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] shq_q, shq_d;
  logic [DataW-1:0] dmag_q, dmag_d;
  logic             neg_q, neg_d;
  logic [DataW-1:0] quot_q, quot_d;

  logic [DataW:0]   rem_sh;
  logic [DataW:0]   diff;
  logic [DataW-1:0] q_next;

  // one restoring step per cycle on magnitudes
  always_comb begin
    rem_sh = {rem_q, shq_q[DataW-1]};
    diff   = rem_sh - {1'b0, dmag_q};
    q_next = {shq_q[DataW-2:0], ~diff[DataW]};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    shq_d  = shq_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      shq_d  = num_i[DataW-1] ? (DataW'(0) - num_i) : num_i;
      dmag_d = den_i[DataW-1] ? (DataW'(0) - den_i) : den_i;
      neg_d  = num_i[DataW-1] ^ den_i[DataW-1];
    end else if (busy_q) begin
      rem_d = diff[DataW] ? rem_sh[DataW-1:0] : diff[DataW-1:0];
      shq_d = q_next;
      cnt_d = cnt_q + CntW'(1);
      if (cnt_q == CntW'(DataW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        quot_d = neg_q ? (DataW'(0) - q_next) : q_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    shq_q  <= shq_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// File: hdl/pkscavg_dp.sv
module pkscavg_dp import pkscavg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  cfg_t                    cfg_i,
  input  ctrl_cmd_t               cmd_i,
  output dp_stat_t                stat_o,
  input  logic signed [DataW-1:0] key_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic signed [DataW-1:0] count_in_i,
  input  logic                    batch_end_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] group_key_o,
  output logic signed [DataW-1:0] total_o,
  output logic signed [DataW-1:0] group_count_o,
  output logic                    zero_divide_o,
  output logic                    final_group_o
);

  // latched item
  logic [DataW-1:0] key_q, value_q, cnt_q;
  logic             last_q;

  // group state
  logic [DataW-1:0] cur_key_q, cur_key_d;
  logic [DataW-1:0] sum_q, sum_d;
  logic [DataW-1:0] count_q, count_d;
  logic             open_q, open_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] o_key_q, o_total_q, o_count_q;
  logic             o_zdiv_q, o_final_q;

  logic [DataW-1:0] cnt_term;
  logic [DataW-1:0] quot;
  logic             div_done;
  logic             cnt_zero;
  logic             out_free;

  pkscavg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start),
    .num_i  (sum_q),
    .den_i  (count_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  // per-record count contribution
  always_comb begin
    unique case (cfg_i.count_mode)
      CNT_RECORD: cnt_term = DataW'(1);
      CNT_FIELD:  cnt_term = cnt_q;
      default:    cnt_term = '0;
    endcase
  end

  assign cnt_zero = (count_q == '0);
  assign out_free = !out_valid_q || out_ready_i;

  // status to controller
  always_comb begin
    stat_o.close_need = open_q && !cfg_i.whole_batch && (key_q != cur_key_q);
    stat_o.need_div   = cfg_i.avg_en && !cnt_zero;
    stat_o.div_done   = div_done;
    stat_o.out_free   = out_free;
    stat_o.last       = last_q;
  end

  // group accumulation, cleared once a group is emitted
  always_comb begin
    cur_key_d = cur_key_q;
    sum_d     = sum_q;
    count_d   = count_q;
    open_d    = open_q;
    if (cmd_i.load_out) begin
      cur_key_d = '0;
      sum_d     = '0;
      count_d   = '0;
      open_d    = 1'b0;
    end else if (cmd_i.add_rec) begin
      open_d = 1'b1;
      if (!open_q) begin
        cur_key_d = key_q;
        sum_d     = value_q;
        count_d   = cnt_term;
      end else begin
        sum_d   = sum_q + value_q;
        count_d = count_q + cnt_term;
      end
    end
  end

  // output handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_key_q   <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_key_q   <= cur_key_d;
      sum_q       <= sum_d;
      count_q     <= count_d;
      open_q      <= open_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      key_q   <= $unsigned(key_i);
      value_q <= $unsigned(value_i);
      cnt_q   <= $unsigned(count_in_i);
      last_q  <= batch_end_i;
    end
    if (cmd_i.load_out) begin
      o_key_q   <= cur_key_q;
      o_count_q <= count_q;
      o_final_q <= cmd_i.emit_final;
      o_zdiv_q  <= cfg_i.avg_en && cnt_zero;
      if (!cfg_i.avg_en) begin
        o_total_q <= sum_q;
      end else if (cnt_zero) begin
        o_total_q <= '0;
      end else begin
        o_total_q <= quot;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign group_key_o   = $signed(o_key_q);
  assign total_o       = $signed(o_total_q);
  assign group_count_o = $signed(o_count_q);
  assign zero_divide_o = o_zdiv_q;
  assign final_group_o = o_final_q;

endmodule

// File: hdl/pkscavg_ctrl.sv
module pkscavg_ctrl import pkscavg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_CALC   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_EMIT   = 3'd4;
  localparam logic [2:0] S_ADD    = 3'd5;

  logic [2:0] state_q, state_d;
  logic       final_q, final_d;

  // group close first, then record add, then batch-end flush
  always_comb begin
    state_d = state_q;
    final_d = final_q;
    cmd_o   = '0;
    cmd_o.emit_final = final_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat_i.close_need) begin
          final_d = 1'b0;
          state_d = S_CALC;
        end else begin
          state_d = S_ADD;
        end
      end
      S_CALC: begin
        if (stat_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d = final_q ? S_IDLE : S_ADD;
        end
      end
      S_ADD: begin
        cmd_o.add_rec = 1'b1;
        if (stat_i.last) begin
          final_d = 1'b1;
          state_d = S_CALC;
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      final_q <= 1'b0;
    end else begin
      state_q <= state_d;
      final_q <= final_d;
    end
  end

endmodule

// File: hdl/per_key_sum_count_average.sv
// an item with no result is loaded, decided and added before ready returns
// a group emission passes through calc and emit, and in average mode the divider (one quotient bit per cycle)
// worst case, key change plus batch end in average mode: two groups emitted for one item
// the result register lets the next item in while a result waits to be taken
// reset: async active low, no group open, count_mode 1, average and whole batch off
module per_key_sum_count_average import pkscavg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [DataW-1:0] key_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic signed [DataW-1:0] count_in_i,
  input  logic                    batch_end_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [DataW-1:0] group_key_o,
  output logic signed [DataW-1:0] total_o,
  output logic signed [DataW-1:0] group_count_o,
  output logic                    zero_divide_o,
  output logic                    final_group_o,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic [1:0]              cfg_data_i
);

  cfg_t      cfg_q, cfg_d;
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COUNT_MODE: cfg_d.count_mode  = cfg_data_i;
        REG_AVG_EN:     cfg_d.avg_en      = cfg_data_i[0];
        REG_WHOLE:      cfg_d.whole_batch = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.count_mode  <= CNT_RECORD;
      cfg_q.avg_en      <= 1'b0;
      cfg_q.whole_batch <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pkscavg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  pkscavg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .key_i        (key_i),
    .value_i      (value_i),
    .count_in_i   (count_in_i),
    .batch_end_i  (batch_end_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .group_key_o  (group_key_o),
    .total_o      (total_o),
    .group_count_o(group_count_o),
    .zero_divide_o(zero_divide_o),
    .final_group_o(final_group_o)
  );

  // zero divide forces the total to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divide_o |-> total_o == '0)
    else $error("zero divide with nonzero total");

  // zero divide only arises from a zero count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_divide_o |-> group_count_o == '0)
    else $error("zero divide with nonzero count");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after accept");

endmodule
